// ===== src/hma_pkg.sv =====
// Package for the heading moving average block: sizes, payload structs and
// the request/response structs between the top level, the ring and the divider.
// No dependencies.
`default_nettype none

package hma_pkg;

  localparam int unsigned MaxWindow = 64;
  localparam int unsigned SampleW   = 9;
  localparam int unsigned CountW    = 7;
  localparam int unsigned AddrW     = $clog2(MaxWindow);
  localparam int unsigned SumW      = $clog2(MaxWindow * (2 ** SampleW));
  localparam int unsigned StepW     = $clog2(SumW + 1);

  localparam logic [CountW-1:0] WindowReset = CountW'(8);

  typedef struct packed {
    logic [SampleW-1:0] heading_sample;
    logic               sample_valid;
  } hma_in_t;

  typedef struct packed {
    logic [SampleW-1:0] average_heading;
    logic [CountW-1:0]  samples_held;
  } hma_out_t;

  typedef struct packed {
    logic               rd_en;
    logic [AddrW-1:0]   rd_addr;
    logic               wr_en;
    logic [AddrW-1:0]   wr_addr;
    logic [SampleW-1:0] wr_data;
  } ring_req_t;

  typedef struct packed {
    logic              start;
    logic [SumW-1:0]   dividend;
    logic [CountW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [SumW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== src/hma_ring.sv =====
// Sample ring of the moving average: one write port, one registered read port.
// Depends on hma_pkg.
`default_nettype none

module hma_ring (
  input  wire                          clk_i,
  input  hma_pkg::ring_req_t           req_i,
  output logic [hma_pkg::SampleW-1:0]  rd_data_o
);
  import hma_pkg::*;

  logic [SampleW-1:0] mem_q [MaxWindow];
  logic [SampleW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== src/hma_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, dividend shifted
// out MSB first while quotient bits shift in. Depends on hma_pkg.
`default_nettype none

module hma_div (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  hma_pkg::div_req_t   req_i,
  output hma_pkg::div_rsp_t   rsp_o
);
  import hma_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [StepW-1:0]  cnt_q;
  logic [CountW-1:0] rem_q;
  logic [CountW-1:0] rem_d;
  logic [SumW-1:0]   quo_q;
  logic [CountW-1:0] dsr_q;
  logic [CountW:0]   trial;
  logic              ge;

  // remainder stays below the divisor, so it fits in CountW bits
  assign trial = {rem_q, quo_q[SumW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign rem_d = ge ? trial[CountW-1:0] - dsr_q : trial[CountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + StepW'(1);
        if (cnt_q == StepW'(SumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[SumW-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ===== src/heading_moving_average.sv =====
// Top level of the heading moving average: window control, running sum and
// output register around hma_ring and hma_div. Depends on hma_pkg.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | hma_in_t
//   out     | output    | out_valid_o/out_stall_i | hma_out_t
//   cfg     | input     | cfg_valid_i/cfg_ready_o | window_length, 7 bits
//
// A transaction runs from accept to result through the ring read and sum
// update, the bit-serial divider (one quotient bit per sum bit), the
// divider's done flag and the load of the output register. Input is
// stalled meanwhile; the next item is taken only after the load, so a new
// item is not accepted before the last one's result is registered. A result
// waiting in the output register does not hold back the next item until
// that item's own quotient is ready. Reset and a window write clear the sum,
// count and pointer; the window resets to 8.
`default_nettype none

module heading_moving_average (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  hma_pkg::hma_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output hma_pkg::hma_out_t                out_data_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [hma_pkg::CountW-1:0]        cfg_data_i
);
  import hma_pkg::*;

  typedef enum logic [3:0] {
    IDLE   = 4'b0001,
    UPDATE = 4'b0010,
    DIVIDE = 4'b0100,
    HOLD   = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [CountW-1:0]  win_q;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [AddrW-1:0]   wp_q, wp_d;
  logic [AddrW-1:0]   ptr_q, ptr;
  logic [SampleW-1:0] sample_q;
  logic               out_valid_q;
  hma_out_t           out_data_q;

  logic               in_accept, cfg_accept, out_free, full;
  logic [CountW-1:0]  win_eff, ptr_inc;
  logic [SampleW-1:0] rd_data;
  ring_req_t          ring_req;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign cfg_ready_o = state_q == IDLE;
  assign in_stall_o  = (state_q != IDLE) || cfg_valid_i;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    if (cfg_data_i == '0) begin
      win_eff = CountW'(1);
    end else if (cfg_data_i > CountW'(MaxWindow)) begin
      win_eff = CountW'(MaxWindow);
    end else begin
      win_eff = cfg_data_i;
    end
  end

  assign ptr     = ({1'b0, wp_q} >= win_q) ? '0 : wp_q;
  assign full    = count_q >= win_q;
  assign ptr_inc = {1'b0, ptr_q} + CountW'(1);
  assign wp_d    = (ptr_inc >= win_q) ? '0 : ptr_inc[AddrW-1:0];
  assign sum_d   = sum_q - (full ? SumW'(rd_data) : '0) + SumW'(sample_q);
  assign count_d = full ? win_q : count_q + CountW'(1);

  assign ring_req.rd_en   = in_accept;
  assign ring_req.rd_addr = ptr;
  assign ring_req.wr_en   = state_q == UPDATE;
  assign ring_req.wr_addr = ptr_q;
  assign ring_req.wr_data = sample_q;

  assign div_req.start    = state_q == UPDATE;
  assign div_req.dividend = sum_d;
  assign div_req.divisor  = count_d;

  hma_ring u_ring (
    .clk_i     (clk_i),
    .req_i     (ring_req),
    .rd_data_o (rd_data)
  );

  hma_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      IDLE:    if (in_accept) state_d = UPDATE;
      UPDATE:  state_d = DIVIDE;
      DIVIDE:  if (div_rsp.done) state_d = HOLD;
      HOLD:    if (out_free) state_d = IDLE;
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      win_q       <= WindowReset;
      sum_q       <= '0;
      count_q     <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_accept) begin
        win_q   <= win_eff;
        sum_q   <= '0;
        count_q <= '0;
        wp_q    <= '0;
      end else if (state_q == UPDATE) begin
        sum_q   <= sum_d;
        count_q <= count_d;
        wp_q    <= wp_d;
      end
      if (state_q == HOLD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ptr_q    <= ptr;
      sample_q <= in_data_i.sample_valid ? in_data_i.heading_sample : '0;
    end
    if (state_q == HOLD && out_free) begin
      out_data_q.average_heading <= div_rsp.quotient[SampleW-1:0];
      out_data_q.samples_held    <= count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_count_le_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= win_q)
    else $error("fill count above window length");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == DIVIDE)
    else $error("divider finished outside divide state");

  a_hold_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == HOLD && !out_valid_q) |=> out_valid_q && state_q == IDLE)
    else $error("free output register not loaded from hold");

endmodule

`default_nettype wire
